// ----- rtl/core/hpec_pkg.sv -----
// Shared types, codes and constants of the haptic paddle effect controller.
`timescale 1ns / 1ps
package hpec_pkg;

  typedef enum logic [1:0] {
    OP_SET_MODE = 2'd0,
    OP_SAMPLE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_SET_DUTY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_SPRING  = 2'd0,
    MODE_DAMPER  = 2'd1,
    MODE_TEXTURE = 2'd2,
    MODE_WALL    = 2'd3
  } mode_e;

  localparam logic [15:0] PwmPeriodReset = 16'd15999;
  localparam logic [15:0] DutyReset      = 16'd999;
  localparam logic [13:0] AngleMask      = 14'h3FFF;
  localparam logic [26:0] AngleRecip     = 27'd5243;
  localparam int unsigned AngleShift     = 19;
  localparam logic [7:0]  SpringHi       = 8'd62;
  localparam logic [7:0]  SpringLo       = 8'd58;
  localparam logic [7:0]  SpringCenter   = 8'd60;
  localparam logic [7:0]  TexA           = 8'd29;
  localparam logic [7:0]  TexB           = 8'd37;
  localparam logic [16:0] DampBand       = 17'd3;
  localparam logic [16:0] DampLimit      = 17'd70;
  localparam logic signed [15:0] WallPos = 16'sd60;
  localparam logic signed [15:0] WallNeg = -16'sd60;

  typedef struct packed {
    op_e         operation;
    logic [1:0]  mode_value;
    logic [15:0] raw_reading;
    logic [15:0] duty_value;
  } item_t;

  typedef struct packed {
    logic        motor_dir;
    logic        motor_off;
    logic [15:0] duty;
    logic [15:0] position;
    logic [7:0]  angle;
    logic [1:0]  mode;
  } result_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

  function automatic logic [7:0] mod_const(input logic [7:0] a, input logic [7:0] m);
    logic [7:0] r;
    r = a;
    for (int i = 0; i < 6; i++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/hpec_in_stage.sv -----
// Input register stage: holds one accepted item until the effect stage takes it.
`timescale 1ns / 1ps
module hpec_in_stage
  import hpec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  item_t      item_i,
  input  logic       advance_i,
  output stage_ctl_t ctl_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign ctl_o.valid   = valid_q;
  assign ctl_o.advance = advance_i;
  assign item_o        = item_q;

endmodule

// ----- rtl/core/hpec_effect.sv -----
// Effect state and the per-item sample and mode rule update.
`timescale 1ns / 1ps
module hpec_effect
  import hpec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stage_ctl_t  ctl_i,
  input  item_t       item_i,
  input  logic [15:0] pwm_period_i,
  output result_t     result_o
);

  logic [1:0]         mode_q, mode_d;
  logic               rearm_q, rearm_d;
  logic signed [15:0] pos_q, pos_d;
  logic [7:0]         angle_q, angle_d;
  logic [7:0]         prev_q, prev_d;
  logic signed [15:0] hold_q, hold_d;
  logic               dir_q, dir_d;
  logic               off_q, off_d;
  logic [15:0]        duty_q, duty_d;

  logic               en;
  logic [26:0]        prod;
  logic [7:0]         samp_angle;
  logic signed [16:0] diff;
  logic signed [16:0] sum;
  logic signed [15:0] samp_pos;
  logic [7:0]         a;
  logic signed [15:0] p;
  logic signed [15:0] hold_eff;
  logic signed [16:0] d;
  logic [16:0]        m;
  logic [7:0]         r1, r2;
  logic               run;

  assign en = ctl_i.valid & ctl_i.advance;

  assign prod       = {13'd0, item_i.raw_reading[13:0] & AngleMask} * AngleRecip;
  assign samp_angle = prod[AngleShift +: 8];
  assign diff       = $signed({9'd0, samp_angle}) - $signed({9'd0, prev_q});
  assign sum        = $signed({pos_q[15], pos_q}) + diff;

  always_comb begin
    if (sum[16] != sum[15]) begin
      samp_pos = sum[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      samp_pos = sum[15:0];
    end
  end

  always_comb begin
    mode_d  = mode_q;
    rearm_d = rearm_q;
    pos_d   = pos_q;
    angle_d = angle_q;
    prev_d  = prev_q;
    hold_d  = hold_q;
    dir_d   = dir_q;
    off_d   = off_q;
    duty_d  = duty_q;
    run     = 1'b0;
    case (item_i.operation)
      OP_SET_MODE: begin
        mode_d  = item_i.mode_value;
        rearm_d = 1'b1;
      end
      OP_SAMPLE: begin
        angle_d = samp_angle;
        prev_d  = samp_angle;
        if (samp_angle != prev_q && samp_angle != 8'd0 && prev_q != 8'd0) begin
          pos_d = samp_pos;
        end
        run = 1'b1;
      end
      OP_TICK: begin
        run = 1'b1;
      end
      OP_SET_DUTY: begin
        duty_d = item_i.duty_value;
      end
      default: begin
        run = 1'b0;
      end
    endcase

    a        = angle_d;
    p        = pos_d;
    hold_eff = rearm_q ? p : hold_q;
    d        = $signed({p[15], p}) - $signed({hold_eff[15], hold_eff});
    m        = d[16] ? 17'(-d) : 17'(d);
    r1       = mod_const(a, TexA);
    r2       = mod_const(a, TexB);

    if (run) begin
      case (mode_q)
        MODE_SPRING: begin
          if (a >= SpringHi || a <= SpringLo) begin
            off_d = 1'b0;
            dir_d = (a > SpringCenter) ? 1'b0 : 1'b1;
          end else begin
            off_d = 1'b1;
          end
          rearm_d = 1'b0;
        end
        MODE_DAMPER: begin
          hold_d = hold_eff;
          if (m >= DampBand) begin
            off_d = 1'b0;
            dir_d = (d > 17'sd0) ? 1'b0 : 1'b1;
            if (m >= DampLimit) begin
              duty_d = 16'd0;
            end
          end else begin
            off_d  = 1'b1;
            duty_d = {4'd0, pwm_period_i[15:4]};
          end
          rearm_d = 1'b0;
        end
        MODE_TEXTURE: begin
          if (r1 inside {[8'd0:8'd2], [8'd27:8'd28]}) begin
            dir_d = 1'b1;
            off_d = 1'b0;
          end else if (r2 inside {[8'd0:8'd2], [8'd35:8'd36]}) begin
            dir_d = 1'b0;
            off_d = 1'b0;
          end else begin
            off_d = 1'b1;
          end
        end
        default: begin
          if (p >= WallPos) begin
            dir_d = 1'b0;
            off_d = 1'b0;
          end else if (p <= WallNeg) begin
            dir_d = 1'b1;
            off_d = 1'b0;
          end else begin
            off_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TEXTURE;
      rearm_q <= 1'b0;
      pos_q   <= '0;
      angle_q <= '0;
      prev_q  <= '0;
      hold_q  <= '0;
      dir_q   <= 1'b0;
      off_q   <= 1'b1;
      duty_q  <= DutyReset;
    end else if (en) begin
      mode_q  <= mode_d;
      rearm_q <= rearm_d;
      pos_q   <= pos_d;
      angle_q <= angle_d;
      prev_q  <= prev_d;
      hold_q  <= hold_d;
      dir_q   <= dir_d;
      off_q   <= off_d;
      duty_q  <= duty_d;
    end
  end

  assign result_o.motor_dir = dir_d;
  assign result_o.motor_off = off_d;
  assign result_o.duty      = duty_d;
  assign result_o.position  = pos_d;
  assign result_o.angle     = angle_d;
  assign result_o.mode      = mode_d;

  a_set_mode_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && item_i.operation == OP_SET_MODE |=> rearm_q && mode_q == $past(item_i.mode_value))
    else $error("set mode did not arm the hold latch");

  a_set_duty_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && item_i.operation == OP_SET_DUTY |=> duty_q == $past(item_i.duty_value))
    else $error("set duty did not write the duty");

  a_tick_keeps_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && item_i.operation == OP_TICK |=> pos_q == $past(pos_q) && angle_q == $past(angle_q))
    else $error("tick changed position or angle");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(pos_q) && $stable(duty_q) && $stable(mode_q))
    else $error("state changed without an item");

endmodule

// ----- rtl/core/haptic_paddle_effect_controller_core.sv -----
// Top level of the haptic paddle effect controller: input stage, effect stage, result register.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o  | operation, mode_value, raw_reading, duty_value
//   out     | output    | out_valid_o/out_stall_i| motor_dir, motor_off, duty, position, angle, mode
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_data_i (pwm_period)
//
// One item per cycle sustained while out_stall_i is low; each accepted item waits in the input
// register and is written to the result register when the effect stage advances.
// Reset clears the handshake state and loads the register reset values; no clearing pass.
// A stalled result holds the effect stage; the input register then holds one more item.
`timescale 1ns / 1ps
module haptic_paddle_effect_controller_core
  import hpec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  mode_value_i,
  input  logic [15:0] raw_reading_i,
  input  logic [15:0] duty_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        motor_dir_o,
  output logic        motor_off_o,
  output logic [15:0] duty_o,
  output logic signed [15:0] position_o,
  output logic [7:0]  angle_o,
  output logic [1:0]  mode_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  item_t      in_item;
  item_t      stage_item;
  stage_ctl_t stage_ctl;
  result_t    result;
  result_t    out_q;
  logic       out_valid_q;
  logic       advance;
  logic [15:0] pwm_period_q;

  assign in_item.operation   = op_e'(operation_i);
  assign in_item.mode_value  = mode_value_i;
  assign in_item.raw_reading = raw_reading_i;
  assign in_item.duty_value  = duty_value_i;

  assign advance = stage_ctl.valid & (~out_valid_q | ~out_stall_i);

  hpec_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .ctl_o      (stage_ctl),
    .item_o     (stage_item)
  );

  hpec_effect u_effect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (stage_ctl),
    .item_i       (stage_item),
    .pwm_period_i (pwm_period_q),
    .result_o     (result)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_period_q <= PwmPeriodReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pwm_period_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign motor_dir_o = out_q.motor_dir;
  assign motor_off_o = out_q.motor_off;
  assign duty_o      = out_q.duty;
  assign position_o  = out_q.position;
  assign angle_o     = out_q.angle;
  assign mode_o      = out_q.mode;

endmodule
